// ----- design/rau_pkg.sv -----
package rau_pkg;

	// Field widths of the transfer payloads.
	localparam int OPERAND_W = 16;
	localparam int OP_W      = 2;
	localparam int NUM_W     = 33;
	localparam int DEN_W     = 31;
	localparam int ERR_W     = 2;

	// Magnitude of a cross product; also the width of the GCD and divider datapath.
	localparam int PROD_W = 2 * OPERAND_W;
	localparam int CNT_W  = $clog2(PROD_W);

	// Operations.
	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_SUB = 2'd1;
	localparam logic [OP_W-1:0] OP_MUL = 2'd2;
	localparam logic [OP_W-1:0] OP_DIV = 2'd3;

	// Error codes.
	localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
	localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd1;
	localparam logic [ERR_W-1:0] ERR_ZERO_DEN = 2'd2;

	// Micro-operations of the datapath.
	localparam int UOP_W = 4;
	localparam logic [UOP_W-1:0] UOP_NOP        = 4'd0;
	localparam logic [UOP_W-1:0] UOP_MUL_N1     = 4'd1;
	localparam logic [UOP_W-1:0] UOP_MUL_D      = 4'd2;
	localparam logic [UOP_W-1:0] UOP_MUL_T      = 4'd3;
	localparam logic [UOP_W-1:0] UOP_ADD_T      = 4'd4;
	localparam logic [UOP_W-1:0] UOP_GCD_INIT   = 4'd5;
	localparam logic [UOP_W-1:0] UOP_GCD_STEP   = 4'd6;
	localparam logic [UOP_W-1:0] UOP_DIV_STEP   = 4'd7;
	localparam logic [UOP_W-1:0] UOP_EMIT_RES   = 4'd8;
	localparam logic [UOP_W-1:0] UOP_EMIT_CONST = 4'd9;

	// Jump conditions.
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] COND_NONE     = 3'd0;
	localparam logic [COND_W-1:0] COND_DIV_ZERO = 3'd1;
	localparam logic [COND_W-1:0] COND_MUL_DIV  = 3'd2;
	localparam logic [COND_W-1:0] COND_DEN_ZERO = 3'd3;
	localparam logic [COND_W-1:0] COND_NUM_ZERO = 3'd4;
	localparam logic [COND_W-1:0] COND_GCD_BUSY = 3'd5;
	localparam logic [COND_W-1:0] COND_DIV_BUSY = 3'd6;

	localparam int STEP_W = 4;

	typedef struct packed {
		logic [OP_W-1:0]             operation;
		logic signed [OPERAND_W-1:0] a_num;
		logic signed [OPERAND_W-1:0] a_den;
		logic signed [OPERAND_W-1:0] b_num;
		logic signed [OPERAND_W-1:0] b_den;
	} rau_in_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] result_num;
		logic [DEN_W-1:0]        result_den;
		logic [ERR_W-1:0]        error_code;
	} rau_out_t;

	typedef struct packed {
		logic [UOP_W-1:0]  uop;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
		logic              last;
		logic [ERR_W-1:0]  err;
	} rau_ctrl_t;

	typedef struct packed {
		logic div_zero;
		logic mul_div;
		logic den_zero;
		logic num_zero;
		logic gcd_busy;
		logic div_busy;
	} rau_status_t;

endpackage

// ----- design/rational_arithmetic_unit_top.sv -----
// Rational arithmetic unit. Each request transfer carries two signed 16-bit
// fractions a_num/a_den and b_num/b_den and an operation (add, subtract,
// multiply, divide); each one yields exactly one response transfer with the
// result reduced to lowest terms and a positive denominator, the sign moved
// into the 33-bit numerator. Dividing by a zero fraction (error 1) or getting
// a zero result denominator (error 2) returns 0/1 with the error code; a zero
// numerator returns 0/1 with no error. The block keeps no state between items
// and works on one item at a time. A small microprogram steps a datapath with
// one 16x16 multiplier for the cross products, a binary GCD unit that takes
// one shift or subtract per cycle, and a two-lane restoring divider that
// retires one quotient bit per cycle for numerator and denominator together.
// A multiply or divide skips the second cross product and its addition,
// which add and subtract need; a normal item then runs the GCD loop, the
// divider steps and the emit step. Error cases and a zero numerator end
// before the GCD loop. The GCD loop is the only data-dependent part. A
// finished result sits in an output register, so the next request is taken
// while that result waits for its transfer.
module rational_arithmetic_unit_top import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  rau_in_t  req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output rau_out_t rsp
);

	logic        busy;
	logic        start;
	logic        hold;
	logic        load;
	rau_ctrl_t   ctrl;
	rau_status_t status;
	rau_out_t    result;
	rau_out_t    rsp_q;
	logic        rsp_valid_q;

	// A new request is taken whenever the sequencer is free, even while the
	// previous result is still waiting in the output register.
	assign req_ready = !busy;
	assign start     = req_valid && req_ready;

	// The output register is full and not being emptied this cycle.
	assign hold = rsp_valid_q && !rsp_ready;

	// The last step of every microprogram path writes the output register.
	assign load = ctrl.last && !hold;

	rau_sequencer u_sequencer (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.hold   (hold),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	rau_datapath u_datapath (
		.clk    (clk),
		.start  (start),
		.req    (req),
		.ctrl   (ctrl),
		.status (status),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload needs no reset; it is qualified by rsp_valid.
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- design/rau_datapath.sv -----
module rau_datapath import rau_pkg::*; (
	input  logic        clk,
	input  logic        start,
	input  rau_in_t     req,
	input  rau_ctrl_t   ctrl,
	output rau_status_t status,
	output rau_out_t    result
);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

	// Magnitude of a two's complement field; the most negative value maps to 2^(W-1).
	function automatic logic [OPERAND_W-1:0] sm_mag(input logic [OPERAND_W-1:0] x);
		return x[OPERAND_W-1] ? (OPERAND_W'(0) - x) : x;
	endfunction

	// One restoring division step: returns the next remainder and quotient shift register.
	function automatic logic [2*PROD_W-1:0] div_lane(input logic [PROD_W-1:0] r,
			input logic [PROD_W-1:0] q, input logic [PROD_W-1:0] dvs);
		logic [PROD_W:0]   trial;
		logic [PROD_W+1:0] diff;
		trial = {r, q[PROD_W-1]};
		diff  = {1'b0, trial} - {2'b00, dvs};
		if (!diff[PROD_W+1]) begin
			return {diff[PROD_W-1:0], q[PROD_W-2:0], 1'b1};
		end
		return {trial[PROD_W-1:0], q[PROD_W-2:0], 1'b0};
	endfunction

	logic [OP_W-1:0]      op_q;
	logic                 an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [OPERAND_W-1:0] an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;
	logic                 n_neg_q, d_neg_q, t_neg_q;
	logic [PROD_W-1:0]    n_mag_q, t_mag_q;
	logic [DEN_W-1:0]     d_mag_q;
	logic [PROD_W-1:0]    u_q, v_q, qn_q, qd_q, rn_q, rd_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [OPERAND_W-1:0] mul_x, mul_y;
	logic                 mul_neg;
	logic [PROD_W-1:0]    mul_p;

	logic [PROD_W:0]      add_diff;
	logic [PROD_W-1:0]    sum_mag;
	logic                 sum_neg;

	logic [PROD_W:0]      gcd_diff;
	logic                 u_eq, u_gt, gcd_done, gcd_shift;
	logic [PROD_W-1:0]    u_nxt, v_nxt;

	logic [NUM_W-1:0]     num_mag;
	logic                 res_neg;

	// Shared multiplier; operand routing depends on the micro-op and the operation.
	always_comb begin
		mul_x   = an_mag_q;
		mul_y   = bd_mag_q;
		mul_neg = an_neg_q ^ bd_neg_q;
		case (ctrl.uop)
			UOP_MUL_N1: begin
				if (op_q == OP_MUL) begin
					mul_y   = bn_mag_q;
					mul_neg = an_neg_q ^ bn_neg_q;
				end
			end
			UOP_MUL_D: begin
				mul_x = ad_mag_q;
				if (op_q == OP_DIV) begin
					mul_y   = bn_mag_q;
					mul_neg = ad_neg_q ^ bn_neg_q;
				end else begin
					mul_neg = ad_neg_q ^ bd_neg_q;
				end
			end
			UOP_MUL_T: begin
				mul_x   = bn_mag_q;
				mul_y   = ad_mag_q;
				mul_neg = bn_neg_q ^ ad_neg_q ^ (op_q == OP_SUB);
			end
			default: begin
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

	// Sign-magnitude addition of the second cross product into the numerator.
	assign add_diff = {1'b0, n_mag_q} - {1'b0, t_mag_q};

	always_comb begin
		if (n_neg_q == t_neg_q) begin
			sum_mag = n_mag_q + t_mag_q;
			sum_neg = n_neg_q;
		end else if (add_diff[PROD_W]) begin
			sum_mag = t_mag_q - n_mag_q;
			sum_neg = t_neg_q;
		end else begin
			sum_mag = add_diff[PROD_W-1:0];
			sum_neg = n_neg_q;
		end
	end

	// Binary GCD step. Common factors of two are stripped from the dividends as
	// well, so the odd part left in u divides them exactly.
	assign gcd_diff = {1'b0, u_q} - {1'b0, v_q};
	assign u_eq     = (u_q == v_q);
	assign u_gt     = !gcd_diff[PROD_W] && !u_eq;
	assign gcd_done = u_q[0] && v_q[0] && u_eq;

	always_comb begin
		u_nxt     = u_q;
		v_nxt     = v_q;
		gcd_shift = 1'b0;
		if (!u_q[0] && !v_q[0]) begin
			u_nxt     = u_q >> 1;
			v_nxt     = v_q >> 1;
			gcd_shift = 1'b1;
		end else if (!u_q[0]) begin
			u_nxt = u_q >> 1;
		end else if (!v_q[0]) begin
			v_nxt = v_q >> 1;
		end else if (u_gt) begin
			u_nxt = gcd_diff[PROD_W-1:0] >> 1;
		end else if (!u_eq) begin
			v_nxt = (v_q - u_q) >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q     <= req.operation;
			an_neg_q <= req.a_num[OPERAND_W-1];
			ad_neg_q <= req.a_den[OPERAND_W-1];
			bn_neg_q <= req.b_num[OPERAND_W-1];
			bd_neg_q <= req.b_den[OPERAND_W-1];
			an_mag_q <= sm_mag(req.a_num);
			ad_mag_q <= sm_mag(req.a_den);
			bn_mag_q <= sm_mag(req.b_num);
			bd_mag_q <= sm_mag(req.b_den);
		end
		case (ctrl.uop)
			UOP_MUL_N1: begin
				n_neg_q <= mul_neg;
				n_mag_q <= mul_p;
			end
			UOP_MUL_D: begin
				d_neg_q <= mul_neg;
				d_mag_q <= mul_p[DEN_W-1:0];
			end
			UOP_MUL_T: begin
				t_neg_q <= mul_neg;
				t_mag_q <= mul_p;
			end
			UOP_ADD_T: begin
				n_neg_q <= sum_neg;
				n_mag_q <= sum_mag;
			end
			UOP_GCD_INIT: begin
				u_q   <= n_mag_q;
				v_q   <= PROD_W'(d_mag_q);
				qn_q  <= n_mag_q;
				qd_q  <= PROD_W'(d_mag_q);
				rn_q  <= '0;
				rd_q  <= '0;
				cnt_q <= '0;
			end
			UOP_GCD_STEP: begin
				u_q <= u_nxt;
				v_q <= v_nxt;
				if (gcd_shift) begin
					qn_q <= qn_q >> 1;
					qd_q <= qd_q >> 1;
				end
			end
			UOP_DIV_STEP: begin
				{rn_q, qn_q} <= div_lane(rn_q, qn_q, u_q);
				{rd_q, qd_q} <= div_lane(rd_q, qd_q, u_q);
				cnt_q        <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		status.div_zero = (op_q == OP_DIV) && (bn_mag_q == '0);
		status.mul_div  = (op_q == OP_MUL) || (op_q == OP_DIV);
		status.den_zero = (d_mag_q == '0);
		status.num_zero = (n_mag_q == '0);
		status.gcd_busy = !gcd_done;
		status.div_busy = (cnt_q != CNT_LAST);
	end

	// The reduced numerator is never zero here, so the sign is just the XOR.
	assign num_mag = {1'b0, qn_q};
	assign res_neg = n_neg_q ^ d_neg_q;

	always_comb begin
		if (ctrl.uop == UOP_EMIT_CONST) begin
			result.result_num = '0;
			result.result_den = DEN_W'(1);
			result.error_code = ctrl.err;
		end else begin
			result.result_num = res_neg ? (NUM_W'(0) - num_mag) : num_mag;
			result.result_den = qd_q[DEN_W-1:0];
			result.error_code = ERR_OK;
		end
	end

endmodule

// ----- design/rau_sequencer.sv -----
module rau_sequencer import rau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        hold,
	input  rau_status_t status,
	output rau_ctrl_t   ctrl,
	output logic        busy
);

	localparam logic [STEP_W-1:0] S_MUL_N1    = 4'd0;
	localparam logic [STEP_W-1:0] S_MUL_D     = 4'd1;
	localparam logic [STEP_W-1:0] S_MUL_T     = 4'd2;
	localparam logic [STEP_W-1:0] S_ADD_T     = 4'd3;
	localparam logic [STEP_W-1:0] S_GCD_INIT  = 4'd4;
	localparam logic [STEP_W-1:0] S_NUM_CHK   = 4'd5;
	localparam logic [STEP_W-1:0] S_GCD_STEP  = 4'd6;
	localparam logic [STEP_W-1:0] S_DIV_STEP  = 4'd7;
	localparam logic [STEP_W-1:0] S_EMIT      = 4'd8;
	localparam logic [STEP_W-1:0] S_ERR_DIV   = 4'd9;
	localparam logic [STEP_W-1:0] S_ERR_DEN   = 4'd10;
	localparam logic [STEP_W-1:0] S_ZERO      = 4'd11;

	function automatic rau_ctrl_t uword(input logic [UOP_W-1:0] uop,
			input logic [COND_W-1:0] cond, input logic [STEP_W-1:0] target,
			input logic last, input logic [ERR_W-1:0] err);
		rau_ctrl_t w;
		w.uop    = uop;
		w.cond   = cond;
		w.target = target;
		w.last   = last;
		w.err    = err;
		return w;
	endfunction

	// Microprogram: one control word per step.
	function automatic rau_ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
		rau_ctrl_t w;
		unique case (step)
			S_MUL_N1:   w = uword(UOP_MUL_N1, COND_DIV_ZERO, S_ERR_DIV, 1'b0, ERR_OK);
			S_MUL_D:    w = uword(UOP_MUL_D, COND_MUL_DIV, S_GCD_INIT, 1'b0, ERR_OK);
			S_MUL_T:    w = uword(UOP_MUL_T, COND_NONE, S_MUL_N1, 1'b0, ERR_OK);
			S_ADD_T:    w = uword(UOP_ADD_T, COND_NONE, S_MUL_N1, 1'b0, ERR_OK);
			S_GCD_INIT: w = uword(UOP_GCD_INIT, COND_DEN_ZERO, S_ERR_DEN, 1'b0, ERR_OK);
			S_NUM_CHK:  w = uword(UOP_NOP, COND_NUM_ZERO, S_ZERO, 1'b0, ERR_OK);
			S_GCD_STEP: w = uword(UOP_GCD_STEP, COND_GCD_BUSY, S_GCD_STEP, 1'b0, ERR_OK);
			S_DIV_STEP: w = uword(UOP_DIV_STEP, COND_DIV_BUSY, S_DIV_STEP, 1'b0, ERR_OK);
			S_EMIT:     w = uword(UOP_EMIT_RES, COND_NONE, S_MUL_N1, 1'b1, ERR_OK);
			S_ERR_DIV:  w = uword(UOP_EMIT_CONST, COND_NONE, S_MUL_N1, 1'b1, ERR_DIV_ZERO);
			S_ERR_DEN:  w = uword(UOP_EMIT_CONST, COND_NONE, S_MUL_N1, 1'b1, ERR_ZERO_DEN);
			S_ZERO:     w = uword(UOP_EMIT_CONST, COND_NONE, S_MUL_N1, 1'b1, ERR_OK);
			default:    w = uword(UOP_EMIT_CONST, COND_NONE, S_MUL_N1, 1'b1, ERR_OK);
		endcase
		return w;
	endfunction

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	rau_ctrl_t         word;
	logic              jump, advance;

	assign word = ucode_rom(step_q);
	assign ctrl = busy_q ? word : uword(UOP_NOP, COND_NONE, S_MUL_N1, 1'b0, ERR_OK);
	assign busy = busy_q;

	always_comb begin
		unique case (word.cond)
			COND_NONE:     jump = 1'b0;
			COND_DIV_ZERO: jump = status.div_zero;
			COND_MUL_DIV:  jump = status.mul_div;
			COND_DEN_ZERO: jump = status.den_zero;
			COND_NUM_ZERO: jump = status.num_zero;
			COND_GCD_BUSY: jump = status.gcd_busy;
			COND_DIV_BUSY: jump = status.div_busy;
			default:       jump = 1'b0;
		endcase
	end

	// The final step waits while the output register still holds an untaken result.
	assign advance = busy_q && !(word.last && hold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= S_MUL_N1;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= S_MUL_N1;
		end else if (advance) begin
			if (word.last) begin
				busy_q <= 1'b0;
			end
			step_q <= jump ? word.target : step_q + 1'b1;
		end
	end

endmodule

// ----- design/rau_checker.sv -----
module rau_checker import rau_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input rau_out_t rsp
);

	// A stalled response keeps its valid and payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Only one item is in work at a time.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in work");

	// Any error reports the fraction 0/1.
	a_err_zero_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.error_code == ERR_DIV_ZERO || rsp.error_code == ERR_ZERO_DEN)
		|-> rsp.result_num == '0 && rsp.result_den == DEN_W'(1))
		else $error("error response is not 0/1");

	// A good result has a legal code and a nonzero denominator.
	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.error_code != ERR_DIV_ZERO && rsp.error_code != ERR_ZERO_DEN
		|-> rsp.error_code == ERR_OK && rsp.result_den != '0)
		else $error("good response with zero denominator or bad code");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ----- verif/rational_arithmetic_unit_top_test.sv -----
`timescale 1ns / 1ps

// Block-level test of the rational arithmetic unit.
//
// Request transfers carry two signed fractions and an operation. For every
// request that the block takes, the test bench works out the reduced result
// on its own and queues it. Each response transfer is then checked field by
// field against the oldest queued result. The block keeps no state, so every
// expected result depends only on its own request.
//
// The run has these steps: plain operations, operand extremes, the error and
// zero cases, a long stretch of random traffic, a burst with no idle cycles
// on either side, and a last stretch of random traffic. Both the request side
// and the response side idle at random, except in that burst.
module rational_arithmetic_unit_top_test;
	import rau_pkg::*;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	rau_in_t  req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	rau_out_t rsp;

	// Expected results, oldest first, one per request the block has taken.
	rau_out_t reduced_results[$];
	int       failures = 0;
	// While this is set, neither side inserts idle cycles.
	bit       no_stall = 1'b0;

	rational_arithmetic_unit_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Works out the result for one request. The cross products of 16-bit
	// operands fit easily in 64 bits, so plain signed integer arithmetic is
	// exact. The denominator is made positive first, and then both parts are
	// divided by the GCD of their magnitudes.
	function automatic rau_out_t reduce_fraction(input rau_in_t item);
		longint   an, ad, bn, bd;
		longint   num, den, p, q, t;
		rau_out_t res;
		an = item.a_num;
		ad = item.a_den;
		bn = item.b_num;
		bd = item.b_den;
		res.result_num = '0;
		res.result_den = DEN_W'(1);
		res.error_code = ERR_OK;
		// A division by a zero fraction is caught before any product is looked at.
		if (item.operation == OP_DIV && bn == 0) begin
			res.error_code = ERR_DIV_ZERO;
			return res;
		end
		case (item.operation)
			OP_ADD: begin
				num = an * bd + bn * ad;
				den = ad * bd;
			end
			OP_SUB: begin
				num = an * bd - bn * ad;
				den = ad * bd;
			end
			OP_MUL: begin
				num = an * bn;
				den = ad * bd;
			end
			default: begin
				num = an * bd;
				den = ad * bn;
			end
		endcase
		if (den == 0) begin
			res.error_code = ERR_ZERO_DEN;
			return res;
		end
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		// This is Euclid's remainder loop on the magnitudes. A zero numerator
		// gives den as the GCD, so the result becomes 0/1.
		p = (num < 0) ? -num : num;
		q = den;
		while (q != 0) begin
			t = p % q;
			p = q;
			q = t;
		end
		res.result_num = NUM_W'(num / p);
		res.result_den = DEN_W'(den / p);
		return res;
	endfunction

	function automatic rau_in_t fraction_pair(input logic [OP_W-1:0] op,
			input int an, input int ad, input int bn, input int bd);
		rau_in_t item;
		item.operation = op;
		item.a_num     = OPERAND_W'(an);
		item.a_den     = OPERAND_W'(ad);
		item.b_num     = OPERAND_W'(bn);
		item.b_den     = OPERAND_W'(bd);
		return item;
	endfunction

	// Random operand values. Half of them span the whole 16-bit range, so that
	// every bit toggles. Small values give frequent common factors and so real
	// reductions. The range ends and zero appear now and then.
	function automatic logic signed [OPERAND_W-1:0] random_operand();
		logic signed [OPERAND_W-1:0] v;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 50) begin
			v = OPERAND_W'($urandom());
		end else if (pick < 80) begin
			v = OPERAND_W'($urandom_range(80));
			v = v - 16'sd40;
		end else if (pick < 88) begin
			v = OPERAND_W'($urandom_range(1, 64) * (1 << $urandom_range(9)));
			if ($urandom_range(1))
				v = -v;
		end else if (pick < 96) begin
			case ($urandom_range(3))
				0: v = 16'sh8000;
				1: v = 16'sh7fff;
				2: v = -16'sd1;
				default: v = 16'sd1;
			endcase
		end else begin
			v = '0;
		end
		return v;
	endfunction

	// Offers one request and holds it until the block takes it. When one
	// request follows another, valid stays high. It is not lowered and raised
	// again in the same step. Before an item there is sometimes a short idle
	// gap on the request side.
	task automatic send_request(input rau_in_t item);
		int gap;
		gap = 0;
		if (!no_stall && $urandom_range(99) < 11)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		reduced_results.push_back(reduce_fraction(item));
	endtask

	// The response side. The handshake is sampled at the same edge at which the
	// block samples it. rsp_ready drops at random, with a chance of 11 in a hundred.
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			check_response(rsp);
		rsp_ready <= no_stall || ($urandom_range(99) >= 11);
	end

	task automatic check_response(input rau_out_t got);
		rau_out_t want;
		if (reduced_results.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected response: %0d/%0d error %0d",
					got.result_num, got.result_den, got.error_code);
		end else begin
			want = reduced_results.pop_front();
			if (got.result_num !== want.result_num || got.result_den !== want.result_den
					|| got.error_code !== want.error_code) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: expected %0d/%0d error %0d, got %0d/%0d error %0d",
						want.result_num, want.result_den, want.error_code,
						got.result_num, got.result_den, got.error_code);
			end
		end
	endtask

	// Each operation on ordinary fractions, with a sign in either place.
	task automatic test_operations();
		send_request(fraction_pair(OP_ADD, 1, 2, 1, 3));
		send_request(fraction_pair(OP_SUB, 1, 2, 3, 4));
		send_request(fraction_pair(OP_MUL, 2, 3, 9, -4));
		send_request(fraction_pair(OP_DIV, -5, 6, 10, -3));
	endtask

	// Most of these operands sit at the ends of the 16-bit range. They drive the cross
	// products, and the sum of two of them, to the widest values the result
	// fields must hold.
	task automatic test_field_extremes();
		send_request(fraction_pair(OP_ADD, -32768, -32768, -32768, -32768));
		send_request(fraction_pair(OP_ADD, 32767, -32768, 32767, -32768));
		send_request(fraction_pair(OP_SUB, -32768, 32767, 32767, -32768));
		send_request(fraction_pair(OP_MUL, -32768, 32767, -32768, 32765));
		send_request(fraction_pair(OP_DIV, 32767, -32768, -32768, 32767));
		send_request(fraction_pair(OP_ADD, -32768, -1, 32767, 1));
		send_request(fraction_pair(OP_MUL, -1, 1, -1, -1));
		send_request(fraction_pair(OP_DIV, 1, 32767, -1, -32768));
		send_request(fraction_pair(OP_SUB, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555));
	endtask

	// These are the error and zero cases. A zero divisor fraction takes
	// precedence over a zero denominator. A zero numerator reduces to 0/1.
	// A divisor whose denominator is zero gives a zero numerator, not an error.
	task automatic test_error_cases();
		send_request(fraction_pair(OP_DIV, 3, 4, 0, 5));
		send_request(fraction_pair(OP_DIV, 3, 0, 0, 5));
		send_request(fraction_pair(OP_DIV, 3, 4, 0, 0));
		send_request(fraction_pair(OP_ADD, 1, 0, 2, 3));
		send_request(fraction_pair(OP_SUB, 1, 2, 2, 0));
		send_request(fraction_pair(OP_MUL, 7, 0, 5, 0));
		send_request(fraction_pair(OP_DIV, 7, 0, 5, 3));
		send_request(fraction_pair(OP_MUL, 0, 7, 5, 3));
		send_request(fraction_pair(OP_DIV, 7, 4, 5, 0));
		send_request(fraction_pair(OP_ADD, -3, 4, 3, 4));
	endtask

	task automatic test_random_traffic(input int count);
		rau_in_t item;
		repeat (count) begin
			item.operation = OP_W'($urandom_range(3));
			item.a_num     = random_operand();
			item.a_den     = random_operand();
			item.b_num     = random_operand();
			item.b_den     = random_operand();
			send_request(item);
		end
	endtask

	// Neither side idles here, so requests follow one another as fast as the
	// block takes them. This also checks that a new request is taken while the
	// previous result is still waiting.
	task automatic test_no_stall_burst(input int count);
		no_stall = 1'b1;
		test_random_traffic(count);
		no_stall = 1'b0;
	endtask

	initial begin
		int waited;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_operations();
		test_field_extremes();
		test_error_cases();
		test_random_traffic(450);
		test_no_stall_burst(150);
		test_random_traffic(150);

		req_valid <= 1'b0;
		waited = 0;
		while (reduced_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		// Allow the length of one full item for a stray response to show up.
		repeat (120) @(posedge clk);
		if (reduced_results.size() != 0) begin
			$display("%0d expected results never arrived", reduced_results.size());
			failures += reduced_results.size();
		end
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// The run has roughly 800 items, and the time they take counts idle gaps
	// and response stalls. This limit is several times that.
	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
